// ===== rtl/windowed_pulse_flow_meter_assert.svh =====
// assertion macros shared by the flow meter rtl
`ifndef WINDOWED_PULSE_FLOW_METER_ASSERT_SVH
`define WINDOWED_PULSE_FLOW_METER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WPFM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wpfm assertion failed");
// next-cycle implication
`define WPFM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpfm assertion failed");
`else
`define WPFM_ASSERT_IMP(label, clk, rst, ante, cons)
`define WPFM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/wpfm_pkg.sv =====
// types, constants and register codes for the windowed pulse flow meter
`timescale 1ns / 1ps
package wpfm_pkg;

   // default ring depth
   localparam int unsigned RING_DEPTH_DEF = 16;

   // numerator width: (n-1) * 60e9 with n up to 256
   localparam int unsigned NUM_W = 44;
   localparam int unsigned DEN_W = 64;

   // 60e9 split into two factors that each fit the 32-bit multiplier
   localparam logic [31:0] SCALE_HI = 32'd60000;
   localparam logic [31:0] SCALE_LO = 32'd1000000;

   localparam logic [23:0] FLOW_MAX = 24'hFFFFFF;

   // register indexes
   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_PPL    = 2'd1;
   localparam logic [1:0] REG_TICK   = 2'd2;

   // register reset values
   localparam logic [31:0] WINDOW_RST = 32'd1000;
   localparam logic [15:0] PPL_RST    = 16'd450;
   localparam logic [15:0] TICK_RST   = 16'd1000;

   typedef struct packed {
      logic        mode;
      logic [31:0] now_ticks;
   } wpfm_req_type;

   typedef struct packed {
      logic [23:0] flow_ml_per_min;
      logic [8:0]  window_count;
      logic [31:0] total_pulses;
   } wpfm_rsp_type;

   // input item kinds
   localparam logic MODE_PULSE  = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   // sequencer states
   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_SCAN      = 9'b000000010,
      ST_CHECK     = 9'b000000100,
      ST_MUL_DEN   = 9'b000001000,
      ST_MUL_SPAN  = 9'b000010000,
      ST_MUL_N     = 9'b000100000,
      ST_MUL_SCALE = 9'b001000000,
      ST_DIV       = 9'b010000000,
      ST_EMIT      = 9'b100000000
   } wpfm_state_type;

endpackage

// ===== rtl/windowed_pulse_flow_meter.sv =====
// top level of the windowed pulse flow meter
//
// req channel (valid/ready) carries one item: mode 0 records a meter pulse
// at now_ticks, mode 1 recomputes the flow from the pulses in the ring whose
// age is within the configured window. rsp channel (valid/ready) returns one
// transaction per item with the held flow, the held window pulse count and
// the running pulse total. the apb port sets the window length in ticks (0x0),
// pulses_per_litre (0x4) and tick_us (0x8); pready is tied high.
// a pulse item passes through the emit state to the output register. an
// update item scans the ring through the single ram read port (one entry
// per cycle, then the ram read register and the age register) and, with
// two or more pulses in the window, runs up to four passes through one
// shared 32x32 multiplier and a 44-step serial divider. an update that
// finds no recent pulse emits zero flow. one item is in flight at a time;
// req_ready is high only while the sequencer is idle.
// reset clears the counters, held results and registers to defaults; the
// ring needs no clearing since only written entries are read. if rsp_ready
// is low the finished transaction waits in the output register and the
// sequencer holds before loading the next one.
`timescale 1ns / 1ps
module windowed_pulse_flow_meter #(
   parameter int unsigned RING_DEPTH = wpfm_pkg::RING_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  wpfm_pkg::wpfm_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wpfm_pkg::wpfm_rsp_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [3:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import wpfm_pkg::*;

`include "windowed_pulse_flow_meter_assert.svh"

   localparam int unsigned IDX_W = $clog2(RING_DEPTH);
   localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);

   wpfm_state_type state_ff, state_in;

   logic [31:0]      window_ff, window_in;
   logic [15:0]      ppl_ff, ppl_in;
   logic [15:0]      tick_ff, tick_in;
   logic [IDX_W-1:0] wr_slot_ff, wr_slot_in;
   logic [CNT_W-1:0] valid_cnt_ff, valid_cnt_in;
   logic [31:0]      last_ff, last_in;
   logic [31:0]      total_ff, total_in;
   logic [23:0]      flow_ff, flow_in;
   logic [8:0]       held_cnt_ff, held_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   wpfm_rsp_type     rsp_data_ff, rsp_data_in;

   logic [31:0]      now_ff, now_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             age_vld_ff, age_vld_in;
   logic [31:0]      age_ff, age_in;
   logic [8:0]       n_ff, n_in;
   logic [31:0]      age_old_ff, age_old_in;
   logic [31:0]      age_new_ff, age_new_in;
   logic [31:0]      span_ff, span_in;
   logic [31:0]      den_ff, den_in;
   logic [63:0]      den64_ff, den64_in;
   logic [31:0]      numhi_ff, numhi_in;

   logic             req_fire;
   logic             csr_wr;
   logic             ram_we;
   logic             ram_re;
   logic [31:0]      ram_rdata;
   logic [31:0]      mul_a;
   logic [31:0]      mul_b;
   logic [63:0]      mul_prod;
   logic [31:0]      span_raw;
   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_quot;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // ring of recent pulse times
   assign ram_we = req_fire && (req_data.mode == MODE_PULSE);
   assign ram_re = (state_ff == ST_SCAN) && (issue_ff < valid_cnt_ff);

   wpfm_ram #(
      .WIDTH (32),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_slot_ff),
      .wr_data (req_data.now_ticks),
      .rd_en   (ram_re),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   // shared multiplier, operands picked by sequencer step
   always_comb begin
      case (state_ff)
         ST_MUL_DEN: begin
            mul_a = {16'd0, ppl_ff};
            mul_b = {16'd0, tick_ff};
         end
         ST_MUL_SPAN: begin
            mul_a = den_ff;
            mul_b = span_ff;
         end
         ST_MUL_N: begin
            mul_a = 32'(n_ff - 9'd1);
            mul_b = SCALE_HI;
         end
         ST_MUL_SCALE: begin
            mul_a = numhi_ff;
            mul_b = SCALE_LO;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_prod = {32'd0, mul_a} * {32'd0, mul_b};
   end

   assign div_start = (state_ff == ST_MUL_SCALE);

   wpfm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (mul_prod[NUM_W-1:0]),
      .denom (den64_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // register read-back
   always_comb begin
      case (paddr[3:2])
         REG_WINDOW: prdata = window_ff;
         REG_PPL:    prdata = {16'd0, ppl_ff};
         REG_TICK:   prdata = {16'd0, tick_ff};
         default:    prdata = '0;
      endcase
   end

   assign span_raw = age_old_ff - age_new_ff;

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      ppl_in       = ppl_ff;
      tick_in      = tick_ff;
      wr_slot_in   = wr_slot_ff;
      valid_cnt_in = valid_cnt_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      flow_in      = flow_ff;
      held_cnt_in  = held_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      now_in       = now_ff;
      issue_in     = issue_ff;
      rd_vld_in    = ram_re;
      age_vld_in   = (state_ff == ST_SCAN) && rd_vld_ff;
      age_in       = now_ff - ram_rdata;
      n_in         = n_ff;
      age_old_in   = age_old_ff;
      age_new_in   = age_new_ff;
      span_in      = span_ff;
      den_in       = den_ff;
      den64_in     = den64_ff;
      numhi_in     = numhi_ff;

      // configuration writes
      if (csr_wr) begin
         case (paddr[3:2])
            REG_WINDOW: window_in = pwdata;
            REG_PPL:    ppl_in    = pwdata[15:0];
            REG_TICK:   tick_in   = pwdata[15:0];
            default:    window_in = window_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in = req_data.now_ticks;
               if (req_data.mode == MODE_PULSE) begin
                  // record the pulse
                  wr_slot_in = (wr_slot_ff == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                      : wr_slot_ff + 1'b1;
                  if (valid_cnt_ff < CNT_W'(RING_DEPTH)) begin
                     valid_cnt_in = valid_cnt_ff + 1'b1;
                  end
                  last_in  = req_data.now_ticks;
                  total_in = total_ff + 32'd1;
                  state_in = ST_EMIT;
               end else if ((valid_cnt_ff == '0) ||
                            ((req_data.now_ticks - last_ff) > window_ff)) begin
                  // empty ring or stale last pulse
                  flow_in     = '0;
                  held_cnt_in = '0;
                  state_in    = ST_EMIT;
               end else begin
                  issue_in   = '0;
                  n_in       = '0;
                  age_old_in = '0;
                  age_new_in = '1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (ram_re) begin
               issue_in = issue_ff + 1'b1;
            end
            // fold one age into count, oldest and newest
            if (age_vld_ff && (age_ff <= window_ff)) begin
               n_in = n_ff + 9'd1;
               if (age_ff > age_old_ff) begin
                  age_old_in = age_ff;
               end
               if (age_ff < age_new_ff) begin
                  age_new_in = age_ff;
               end
            end
            if (!ram_re && !rd_vld_ff && !age_vld_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            held_cnt_in = n_ff;
            span_in     = (span_raw == '0) ? 32'd1 : span_raw;
            if (n_ff < 9'd2) begin
               flow_in  = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL_DEN;
            end
         end
         ST_MUL_DEN: begin
            den_in   = mul_prod[31:0];
            state_in = ST_MUL_SPAN;
         end
         ST_MUL_SPAN: begin
            if (den_ff == '0) begin
               flow_in  = FLOW_MAX;
               state_in = ST_EMIT;
            end else begin
               den64_in = mul_prod;
               state_in = ST_MUL_N;
            end
         end
         ST_MUL_N: begin
            numhi_in = mul_prod[31:0];
            state_in = ST_MUL_SCALE;
         end
         ST_MUL_SCALE: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               flow_in  = (div_quot > NUM_W'(FLOW_MAX)) ? FLOW_MAX : div_quot[23:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.flow_ml_per_min  = flow_ff;
               rsp_data_in.window_count     = held_cnt_ff;
               rsp_data_in.total_pulses     = total_ff;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RST;
         ppl_ff       <= PPL_RST;
         tick_ff      <= TICK_RST;
         wr_slot_ff   <= '0;
         valid_cnt_ff <= '0;
         last_ff      <= '0;
         total_ff     <= '0;
         flow_ff      <= '0;
         held_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         age_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         ppl_ff       <= ppl_in;
         tick_ff      <= tick_in;
         wr_slot_ff   <= wr_slot_in;
         valid_cnt_ff <= valid_cnt_in;
         last_ff      <= last_in;
         total_ff     <= total_in;
         flow_ff      <= flow_in;
         held_cnt_ff  <= held_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         age_vld_ff   <= age_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      now_ff      <= now_in;
      issue_ff    <= issue_in;
      age_ff      <= age_in;
      n_ff        <= n_in;
      age_old_ff  <= age_old_in;
      age_new_ff  <= age_new_in;
      span_ff     <= span_in;
      den_ff      <= den_in;
      den64_ff    <= den64_in;
      numhi_ff    <= numhi_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `WPFM_ASSERT_NXT(a_busy_after_accept, clock, reset, req_fire, !req_ready)
   `WPFM_ASSERT_IMP(a_ring_fill_bound, clock, reset, 1'b1,
                    valid_cnt_ff <= CNT_W'(RING_DEPTH))
   `WPFM_ASSERT_IMP(a_window_le_fill, clock, reset, 1'b1,
                    held_cnt_ff <= 9'(valid_cnt_ff))
   `WPFM_ASSERT_IMP(a_flow_needs_two, clock, reset, flow_ff != '0,
                    held_cnt_ff >= 9'd2)
   `WPFM_ASSERT_IMP(a_div_done_in_div, clock, reset, div_done, state_ff == ST_DIV)

endmodule

// ===== rtl/wpfm_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module wpfm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wpfm_div.sv =====
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wpfm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wpfm_pkg::NUM_W-1:0]    numer,
   input  logic [wpfm_pkg::DEN_W-1:0]    denom,
   output logic                          done,
   output logic [wpfm_pkg::NUM_W-1:0]    quot
);
   import wpfm_pkg::*;

   localparam int unsigned CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;

   // one shift-subtract step
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
         end
         quo_in = {quo_ff[NUM_W-2:0], ~diff[DEN_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule
